/* sv/lgrs_pkg.sv */
// Shared types, constants and helpers for the Life row generator.
// No dependencies; used by every module of the block.
package lgrs_pkg;

  localparam int unsigned ROW_W     = 64;
  localparam int unsigned LANE_COLS = 8;
  localparam int unsigned NUM_LANES = ROW_W / LANE_COLS;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned CNT_MAX   = 4;  // neighbour count width is 4 bits

  // Configuration register map, indexed by paddr[2].
  localparam logic REG_COLS_IN_USE = 1'b0;
  localparam logic [CNT_W-1:0] COLS_RESET = CNT_W'(ROW_W);

  typedef struct packed {
    logic             frame_done;
    logic [ROW_W-1:0] next_cells;
  } lgrs_result_t;

  // Columns at or above the width in use are dead.
  function automatic logic [ROW_W-1:0] col_mask(input logic [CNT_W-1:0] cols);
    logic [ROW_W-1:0] m;
    for (int k = 0; k < ROW_W; k++) begin
      m[k] = (CNT_W'(k) < cols);
    end
    return m;
  endfunction

endpackage

/* sv/life_generation_row_step.sv */
// Top level of the streaming Life (B3/S23) row generator.
// Depends on lgrs_pkg, lgrs_lane and lgrs_outq.
//
// Usage: rows of one generation enter on the s_axis channel, one row per
// item, column k in bit k, with tlast on the frame's final row. Each row
// that follows a held row releases the next generation of the held row on
// m_axis. The final row releases one more item, marked with tlast, for
// itself with a dead row below. The first row of a frame gives no item
// unless it is also the last. The APB register cols_in_use (address 0,
// reset 64) masks columns at or above it as dead.
// Each result is registered in the result queue before it is offered on
// m_axis; the extra item for the final row comes from the flush pass.
// Throughput: one row per cycle while the result queue has space; after
// the final row of a frame with more than one row, s_axis_tready stays low
// for the flush pass, as the eight column lanes compute one result per cycle.
// Reset clears the held rows, so a new frame may start at once. When the
// receiver stalls, a two-entry result queue absorbs up to two items, after
// which s_axis_tready drops until an item is taken.
module life_generation_row_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] row_cells
  input  logic        s_axis_tlast,   // last_row
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] next_cells
  output logic        m_axis_tlast,   // frame_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned RW = lgrs_pkg::ROW_W;
  localparam int unsigned LC = lgrs_pkg::LANE_COLS;

  logic [lgrs_pkg::CNT_W-1:0] cols_q;
  logic [RW-1:0] above_q, above_d;
  logic [RW-1:0] middle_q, middle_d;
  logic          mvalid_q, mvalid_d;
  logic          flush_q, flush_d;

  logic          space, accept, flush_fire, push;
  logic [RW-1:0] mask, up, mid, down, lanes_out;
  logic [RW+1:0] up_ext, mid_ext, down_ext;
  lgrs_pkg::lgrs_result_t res, q_out;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lgrs_pkg::REG_COLS_IN_USE)
                ? {{(32 - lgrs_pkg::CNT_W){1'b0}}, cols_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= lgrs_pkg::COLS_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == lgrs_pkg::REG_COLS_IN_USE)) begin
      cols_q <= pwdata[lgrs_pkg::CNT_W-1:0];
    end
  end

  // Row window control
  assign s_axis_tready = !flush_q && space;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign flush_fire    = flush_q && space;
  assign push          = flush_fire || (accept && (mvalid_q || s_axis_tlast));

  always_comb begin
    above_d  = above_q;
    middle_d = middle_q;
    mvalid_d = mvalid_q;
    flush_d  = flush_q;
    if (flush_fire) begin
      above_d  = '0;
      middle_d = '0;
      mvalid_d = 1'b0;
      flush_d  = 1'b0;
    end else if (accept) begin
      // A single-row frame is finished in one pass and leaves the window empty.
      if (!(s_axis_tlast && !mvalid_q)) begin
        above_d  = mvalid_q ? middle_q : '0;
        middle_d = s_axis_tdata;
        mvalid_d = 1'b1;
        flush_d  = s_axis_tlast;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q  <= '0;
      middle_q <= '0;
      mvalid_q <= 1'b0;
      flush_q  <= 1'b0;
    end else begin
      above_q  <= above_d;
      middle_q <= middle_d;
      mvalid_q <= mvalid_d;
      flush_q  <= flush_d;
    end
  end

  // Operand selection: the flush pass uses a dead row below the last row.
  assign mask = lgrs_pkg::col_mask(cols_q);
  assign up   = above_q & mask;
  assign mid  = (flush_q || mvalid_q) ? (middle_q & mask) : (s_axis_tdata & mask);
  assign down = (!flush_q && mvalid_q) ? (s_axis_tdata & mask) : '0;

  assign up_ext   = {1'b0, up, 1'b0};
  assign mid_ext  = {1'b0, mid, 1'b0};
  assign down_ext = {1'b0, down, 1'b0};

  for (genvar l = 0; l < lgrs_pkg::NUM_LANES; l++) begin : g_lane
    lgrs_lane u_lane (
      .up_i   (up_ext[l*LC +: LC+2]),
      .mid_i  (mid_ext[l*LC +: LC+2]),
      .down_i (down_ext[l*LC +: LC+2]),
      .next_o (lanes_out[l*LC +: LC])
    );
  end

  // Merge the lanes and apply the column mask once more.
  assign res.next_cells = lanes_out & mask;
  assign res.frame_done = flush_q || (s_axis_tlast && !mvalid_q);

  lgrs_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (q_out)
  );

  assign m_axis_tdata = q_out.next_cells;
  assign m_axis_tlast = q_out.frame_done;

endmodule

/* sv/lgrs_lane.sv */
// One lane of the Life row generator: next state of LANE_COLS columns.
// Depends on lgrs_pkg. Each window carries one extra column on either side.
module lgrs_lane (
  input  logic [lgrs_pkg::LANE_COLS+1:0] up_i,
  input  logic [lgrs_pkg::LANE_COLS+1:0] mid_i,
  input  logic [lgrs_pkg::LANE_COLS+1:0] down_i,
  output logic [lgrs_pkg::LANE_COLS-1:0] next_o
);

  always_comb begin
    logic [lgrs_pkg::CNT_MAX-1:0] n;
    for (int c = 0; c < lgrs_pkg::LANE_COLS; c++) begin
      n = lgrs_pkg::CNT_MAX'(up_i[c]) + lgrs_pkg::CNT_MAX'(up_i[c+1])
        + lgrs_pkg::CNT_MAX'(up_i[c+2]) + lgrs_pkg::CNT_MAX'(mid_i[c])
        + lgrs_pkg::CNT_MAX'(mid_i[c+2]) + lgrs_pkg::CNT_MAX'(down_i[c])
        + lgrs_pkg::CNT_MAX'(down_i[c+1]) + lgrs_pkg::CNT_MAX'(down_i[c+2]);
      // Three neighbours give birth or survival; two keep the present state.
      next_o[c] = (n == lgrs_pkg::CNT_MAX'(3))
               || ((n == lgrs_pkg::CNT_MAX'(2)) && mid_i[c+1]);
    end
  end

endmodule

/* sv/lgrs_outq.sv */
// Two-entry result queue that separates the generator from the output stream.
// Depends on lgrs_pkg for the result type.
module lgrs_outq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  lgrs_pkg::lgrs_result_t push_data_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output lgrs_pkg::lgrs_result_t data_o
);

  lgrs_pkg::lgrs_result_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* sv/lgrs_checker.sv */
// Port-level checks for the Life row generator, bound to the top level.
// Depends only on the ports of life_generation_row_step.
module lgrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // A stalled result item stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item withdrawn while stalled");

  // A stalled result item keeps its payload.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // The width register reads back what was last written to it.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2]
      |-> prdata[6:0] == $past(pwdata[6:0]))
    else $error("cols_in_use readback mismatch");

  // No result is offered in the first cycle after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result offered straight after reset");

endmodule

bind life_generation_row_step lgrs_checker u_lgrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

/* sim/tb_life_generation_row_step.sv */
// Self-checking testbench for the streaming Life (B3/S23) row generator.
// Depends on lgrs_pkg and life_generation_row_step; rows are predicted in-bench and
// compared with every item the block emits.
module tb_life_generation_row_step;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam logic [2:0]  ADDR_COLS      = {lgrs_pkg::REG_COLS_IN_USE, 2'b00};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_tdata = '0;   // [63:0] row_cells
  logic        s_tlast = 1'b0; // last_row
  logic        m_axis_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_axis_tdata;   // [63:0] next_cells
  logic        m_axis_tlast;   // frame_done
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  life_generation_row_step uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the three-row window and the width register.
  logic [lgrs_pkg::CNT_W-1:0] cols_cfg;
  logic [63:0]                row_above;
  logic [63:0]                row_middle;
  logic                       middle_held;
  lgrs_pkg::lgrs_result_t     pending_rows[$];

  int n_errors = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_reqs = 0;

  function automatic logic [63:0] width_mask(input logic [lgrs_pkg::CNT_W-1:0] c);
    int w;
    w = (c > 64) ? 64 : int'(c);
    if (w == 64) return {64{1'b1}};
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic int bit_of(input logic [63:0] row, input int k);
    return (k < 0 || k > 63) ? 0 : int'(row[k]);
  endfunction

  function automatic logic [63:0] life_next_row(input logic [63:0] up, input logic [63:0] mid,
                                                input logic [63:0] dn);
    logic [63:0] m;
    logic [63:0] res;
    int n;
    m   = width_mask(cols_cfg);
    up  = up & m;
    mid = mid & m;
    dn  = dn & m;
    res = '0;
    for (int k = 0; k < 64; k++) begin
      n = bit_of(up, k - 1) + bit_of(up, k) + bit_of(up, k + 1)
        + bit_of(mid, k - 1) + bit_of(mid, k + 1)
        + bit_of(dn, k - 1) + bit_of(dn, k) + bit_of(dn, k + 1);
      if (n == 3) res[k] = 1'b1;
      else if (n == 2) res[k] = mid[k];
      else res[k] = 1'b0;
    end
    return res & m;
  endfunction

  task automatic advance_window(input logic [63:0] row, input logic last);
    lgrs_pkg::lgrs_result_t r;
    if (middle_held) begin
      r.next_cells = life_next_row(row_above, row_middle, row);
      r.frame_done = 1'b0;
      pending_rows.push_back(r);
    end
    row_above   = middle_held ? row_middle : '0;
    row_middle  = row;
    middle_held = 1'b1;
    if (last) begin
      r.next_cells = life_next_row(row_above, row_middle, '0);
      r.frame_done = 1'b1;
      pending_rows.push_back(r);
      row_above   = '0;
      row_middle  = '0;
      middle_held = 1'b0;
    end
  endtask

  // Entered and left at a falling edge; tvalid stays high after the item is taken so that
  // back-to-back items need no second assignment in one step.
  task automatic send_row(input logic [63:0] row, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= row;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_window(row, last);
    @(negedge clk_i);
  endtask

  // Stops offering items and waits until the block has delivered everything.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes cols_in_use with random upper bits, then reads it back.
  task automatic program_width(input logic [lgrs_pkg::CNT_W-1:0] cols);
    logic [31:0] wdata;
    wdata = $urandom();
    wdata[lgrs_pkg::CNT_W-1:0] = cols;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_COLS;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cols_cfg = wdata[lgrs_pkg::CNT_W-1:0];
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(cols_cfg)) begin
      $display("%0t: cols_in_use read back expected %0d actual %0d", $time, cols_cfg, prdata);
      n_errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [63:0] rand_row();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    a = {$urandom(), $urandom()};
    b = {$urandom(), $urandom()};
    c = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0, 1, 2: return a;
      3, 4:    return a & b & c;
      5:       return a & b;
      6:       return a | b;
      7:       return {64{1'b1}};
      8:       return '0;
      default: return (64'd7 << $urandom_range(0, 61)) | (a & b & c & 64'h1);
    endcase
  endfunction

  function automatic logic [lgrs_pkg::CNT_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return lgrs_pkg::CNT_W'(64);
      4, 5, 6:    return lgrs_pkg::CNT_W'($urandom_range(1, 64));
      7:          return '0;
      8:          return lgrs_pkg::CNT_W'($urandom_range(65, 127));
      default:    return lgrs_pkg::CNT_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever the test asks for one.
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    lgrs_pkg::lgrs_result_t want;
    if (rst_ni && m_axis_tvalid && m_tready) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected item next_cells %h frame_done %b",
                 $time, m_axis_tdata, m_axis_tlast);
        n_errors++;
      end else begin
        want = pending_rows.pop_front();
        if (m_axis_tdata !== want.next_cells) begin
          $display("%0t: next_cells expected %h actual %h", $time, want.next_cells, m_axis_tdata);
          n_errors++;
        end
        if (m_axis_tlast !== want.frame_done) begin
          $display("%0t: frame_done expected %b actual %b", $time, want.frame_done, m_axis_tlast);
          n_errors++;
        end
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_single_row_frames();
    send_row({64{1'b1}}, 1'b1);
    send_row('0, 1'b1);
    send_row(64'h8000_0000_0000_0001, 1'b1);
    settle();
  endtask

  task automatic test_row_extremes();
    send_row({64{1'b1}}, 1'b0);
    send_row({64{1'b1}}, 1'b0);
    send_row({64{1'b1}}, 1'b1);
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'hC000_0000_0000_0003, 1'b0);
    send_row(64'h0000_0000_0000_0000, 1'b1);
    // A blinker flips from horizontal to vertical.
    send_row(64'h0, 1'b0);
    send_row(64'h7 << 30, 1'b0);
    send_row(64'h0, 1'b1);
    settle();
  endtask

  task automatic test_column_widths();
    program_width('0);
    send_row({64{1'b1}}, 1'b0);
    send_row({64{1'b1}}, 1'b1);
    settle();
    program_width(lgrs_pkg::CNT_W'(127));
    send_row(64'hE000_0000_0000_0007, 1'b0);
    send_row(64'hE000_0000_0000_0007, 1'b1);
    settle();
    program_width(lgrs_pkg::CNT_W'(1));
    send_row({64{1'b1}}, 1'b0);
    send_row({64{1'b1}}, 1'b1);
    settle();
    program_width(lgrs_pkg::CNT_W'(65));
    send_row({64{1'b1}}, 1'b1);
    settle();
    program_width(lgrs_pkg::CNT_W'(64));
  endtask

  // The width in force at each computation also masks rows stored before the change.
  task automatic test_width_change_mid_frame();
    send_row({64{1'b1}}, 1'b0);
    settle();
    program_width(lgrs_pkg::CNT_W'(5));
    send_row({64{1'b1}}, 1'b0);
    settle();
    program_width(lgrs_pkg::CNT_W'(64));
    send_row({64{1'b1}}, 1'b1);
    settle();
  endtask

  task automatic test_random_frames(input int n_rows);
    int sent;
    int len;
    sent = 0;
    while (sent < n_rows) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        program_width(pick_width());
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_row(rand_row(), i == len - 1);
        if (i == 0 && len > 2 && $urandom_range(0, 7) == 0) begin
          settle();
          program_width(pick_width());
        end
      end
      sent += len;
    end
    settle();
  endtask

  // The receiver holds off while rows keep coming, so the result queue fills and
  // s_axis_tready must drop.
  task automatic test_output_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_reqs++;
    for (int i = 0; i < 24; i++) send_row(rand_row(), (i % 8) == 7);
    settle();
  endtask

  initial begin
    cols_cfg    = lgrs_pkg::COLS_RESET;
    row_above   = '0;
    row_middle  = '0;
    middle_held = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_pct = 22;
    snk_idle_pct = 63;
    test_single_row_frames();
    test_row_extremes();
    test_column_widths();
    test_width_change_mid_frame();
    test_random_frames(220);

    src_idle_pct = 63;
    snk_idle_pct = 22;
    test_random_frames(200);

    test_output_backpressure();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_frames(220);

    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
